>>> sv/video_test_pattern_generator_defines.svh
// assertion macros shared by the test pattern generator checker
// no dependencies; the using module must provide i_clk and i_rst_n
`ifndef VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH
`define VIDEO_TEST_PATTERN_GENERATOR_DEFINES_SVH

// same-edge implication, off while reset is low
`define VTPG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-edge implication, off while reset is low
`define VTPG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/vtpg_pkg.sv
// shared types, constants and color tables of the test pattern generator
// no dependencies
`timescale 1ns / 1ps

package vtpg_pkg;

    // raster bounds
    localparam int MAX_LINE_PIXELS = 4096;
    localparam int MAX_FRAME_LINES = 4096;
    localparam int POS_W  = $clog2(MAX_LINE_PIXELS);
    localparam int ROW_W  = $clog2(MAX_FRAME_LINES);
    localparam int EDGE_W = POS_W + 1;
    // size registers as written
    localparam int SIZE_W = 13;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_MODE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = CFG_INDEX_W'(1);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] CFG_FILL_COLOR   = CFG_INDEX_W'(3);
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_LEVEL  = CFG_INDEX_W'(4);
    localparam logic [CFG_INDEX_W-1:0] CFG_CHECKER_SIZE = CFG_INDEX_W'(5);

    typedef enum logic [1:0] {
        MODE_SOLID   = 2'd0,
        MODE_BARS    = 2'd1,
        MODE_CHECKER = 2'd2
    } t_mode;

    // settings and bar geometry handed to the pixel path
    typedef struct packed {
        logic [1:0]                   mode;
        logic [23:0]                  fill;
        logic [7:0]                   alpha;
        logic [POS_W-1:0]             w_last;
        logic [ROW_W-1:0]             h_last;
        logic [SIZE_W-1:0]            cell_last;
        logic [ROW_W-1:0]             band2_top;
        logic [ROW_W-1:0]             band3_top;
        logic [6:0][EDGE_W-1:0]       bar_edge;
        logic [3:0][EDGE_W-1:0]       lower_edge;
        logic [EDGE_W-1:0]            pluge_mid;
        logic [EDGE_W-1:0]            pluge_high;
    } t_cfg;

    // packed rgb, red in the top byte
    localparam logic [23:0] UPPER_RGB [7] = '{
        24'hC0C0C0, 24'hC0C000, 24'h00C0C0, 24'h00C000,
        24'hC000C0, 24'hC00000, 24'h0000C0};
    localparam logic [23:0] SECOND_RGB [7] = '{
        24'h0000C0, 24'h131313, 24'hC000C0, 24'h131313,
        24'h00C0C0, 24'h131313, 24'hC0C0C0};
    localparam logic [23:0] LOWER_RGB [4] = '{
        24'h00214C, 24'hFFFFFF, 24'h32006A, 24'h131313};
    localparam logic [23:0] PLUGE_LOW_RGB  = 24'h090909;
    localparam logic [23:0] PLUGE_MID_RGB  = 24'h131313;
    localparam logic [23:0] PLUGE_HIGH_RGB = 24'h1D1D1D;
    localparam logic [23:0] GRAY_RGB       = 24'h131313;

endpackage

>>> sv/vtpg_geom.sv
// configuration registers and derived bar geometry of the test pattern generator
// depends on vtpg_pkg
`timescale 1ns / 1ps

module vtpg_geom (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vtpg_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output vtpg_pkg::t_cfg                       o_cfg
);

    localparam int POS_W  = vtpg_pkg::POS_W;
    localparam int ROW_W  = vtpg_pkg::ROW_W;
    localparam int EDGE_W = vtpg_pkg::EDGE_W;
    localparam int SIZE_W = vtpg_pkg::SIZE_W;
    localparam int BW_W   = POS_W - 2;
    localparam int SW_W   = POS_W - 4;
    localparam int H2_W   = ROW_W - 3;

    // reciprocals for division by 7, 21, 3 and 25
    localparam int BW_RECIP = 9363;
    localparam int SW_RECIP = 3121;
    localparam int H1_RECIP = 21846;
    localparam int H2_RECIP = 41944;

    localparam int RST_WIDTH   = 1920;
    localparam int RST_HEIGHT  = 1080;
    localparam int RST_CHECKER = 10;
    localparam int DEF_BW      = (RST_WIDTH + 6) / 7;
    localparam int DEF_SW      = (RST_WIDTH + 6) / 21;
    localparam int DEF_H1      = (2 * RST_HEIGHT + 2) / 3;
    localparam int DEF_H2      = (2 * RST_HEIGHT + 24) / 25;

    logic [1:0]         r_mode;
    logic [23:0]        r_fill;
    logic [7:0]         r_alpha;
    logic [POS_W-1:0]   r_w_last;
    logic [ROW_W-1:0]   r_h_last;
    logic [SIZE_W-1:0]  r_cell_last;
    logic [BW_W-1:0]    r_bw;
    logic [SW_W-1:0]    r_sw;
    logic [ROW_W-1:0]   r_h1;
    logic [H2_W-1:0]    r_h2;

    logic [6:0][EDGE_W-1:0] r_bar_edge;
    logic [3:0][EDGE_W-1:0] r_lower_edge;
    logic [EDGE_W-1:0]      r_pluge_mid;
    logic [EDGE_W-1:0]      r_pluge_high;
    logic [ROW_W-1:0]       r_band3_top;

    logic [SIZE_W-1:0]  wr_size;
    logic [POS_W:0]     eff_w;
    logic [ROW_W:0]     eff_h;
    logic [POS_W:0]     w_plus;
    logic [ROW_W+1:0]   h1_num;
    logic [ROW_W+1:0]   h2_num;
    logic [POS_W+16:0]  bw_prod;
    logic [POS_W+16:0]  sw_prod;
    logic [ROW_W+17:0]  h1_prod;
    logic [ROW_W+19:0]  h2_prod;

    logic [POS_W-1:0]   n_w_last;
    logic [ROW_W-1:0]   n_h_last;
    logic [SIZE_W-1:0]  n_cell_last;
    logic [BW_W-1:0]    n_bw;
    logic [SW_W-1:0]    n_sw;
    logic [ROW_W-1:0]   n_h1;
    logic [H2_W-1:0]    n_h2;

    logic [EDGE_W-1:0]  bw_x1;
    logic [EDGE_W-1:0]  bw_x2;
    logic [EDGE_W-1:0]  bw_x3;
    logic [EDGE_W-1:0]  bw_x4;
    logic [EDGE_W-1:0]  bw_x5;
    logic [EDGE_W-1:0]  tw;
    logic [EDGE_W-1:0]  sw_x1;

    // write side: saturate sizes, then one reciprocal multiply each
    always_comb begin
        wr_size = i_cfg_data[SIZE_W-1:0];

        if (wr_size == '0) begin
            eff_w = (POS_W+1)'(1);
        end else if (32'(wr_size) > vtpg_pkg::MAX_LINE_PIXELS) begin
            eff_w = (POS_W+1)'(vtpg_pkg::MAX_LINE_PIXELS);
        end else begin
            eff_w = (POS_W+1)'(wr_size);
        end

        if (wr_size == '0) begin
            eff_h = (ROW_W+1)'(1);
        end else if (32'(wr_size) > vtpg_pkg::MAX_FRAME_LINES) begin
            eff_h = (ROW_W+1)'(vtpg_pkg::MAX_FRAME_LINES);
        end else begin
            eff_h = (ROW_W+1)'(wr_size);
        end

        w_plus  = eff_w + (POS_W+1)'(6);
        bw_prod = (POS_W+17)'(w_plus) * (POS_W+17)'(BW_RECIP);
        sw_prod = (POS_W+17)'(w_plus) * (POS_W+17)'(SW_RECIP);
        n_bw    = bw_prod[16 +: BW_W];
        n_sw    = sw_prod[16 +: SW_W];
        n_w_last = POS_W'(eff_w - (POS_W+1)'(1));

        h1_num  = {eff_h, 1'b0} + (ROW_W+2)'(2);
        h2_num  = {eff_h, 1'b0} + (ROW_W+2)'(24);
        h1_prod = (ROW_W+18)'(h1_num) * (ROW_W+18)'(H1_RECIP);
        h2_prod = (ROW_W+20)'(h2_num) * (ROW_W+20)'(H2_RECIP);
        n_h1    = h1_prod[16 +: ROW_W];
        n_h2    = h2_prod[20 +: H2_W];
        n_h_last = ROW_W'(eff_h - (ROW_W+1)'(1));

        n_cell_last = (wr_size == '0) ? '0 : wr_size - SIZE_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= vtpg_pkg::MODE_SOLID;
            r_fill      <= 24'hFF0000;
            r_alpha     <= 8'hFF;
            r_w_last    <= POS_W'(RST_WIDTH - 1);
            r_h_last    <= ROW_W'(RST_HEIGHT - 1);
            r_cell_last <= SIZE_W'(RST_CHECKER - 1);
            r_bw        <= BW_W'(DEF_BW);
            r_sw        <= SW_W'(DEF_SW);
            r_h1        <= ROW_W'(DEF_H1);
            r_h2        <= H2_W'(DEF_H2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                vtpg_pkg::CFG_PATTERN_MODE: begin
                    r_mode <= i_cfg_data[1:0];
                end
                vtpg_pkg::CFG_FRAME_WIDTH: begin
                    r_w_last <= n_w_last;
                    r_bw     <= n_bw;
                    r_sw     <= n_sw;
                end
                vtpg_pkg::CFG_FRAME_HEIGHT: begin
                    r_h_last <= n_h_last;
                    r_h1     <= n_h1;
                    r_h2     <= n_h2;
                end
                vtpg_pkg::CFG_FILL_COLOR: begin
                    r_fill <= i_cfg_data[23:0];
                end
                vtpg_pkg::CFG_ALPHA_LEVEL: begin
                    r_alpha <= i_cfg_data[7:0];
                end
                vtpg_pkg::CFG_CHECKER_SIZE: begin
                    r_cell_last <= n_cell_last;
                end
                default: begin
                end
            endcase
        end
    end

    // second step: bar and band edges from the registered widths and heights
    always_comb begin
        bw_x1 = EDGE_W'(r_bw);
        bw_x2 = bw_x1 << 1;
        bw_x3 = bw_x2 + bw_x1;
        bw_x4 = bw_x1 << 2;
        bw_x5 = bw_x4 + bw_x1;
        tw    = (bw_x4 + bw_x1 + EDGE_W'(2)) >> 2;
        sw_x1 = EDGE_W'(r_sw);
    end

    always_ff @(posedge i_clk) begin
        r_bar_edge[0]   <= bw_x1;
        r_bar_edge[1]   <= bw_x2;
        r_bar_edge[2]   <= bw_x3;
        r_bar_edge[3]   <= bw_x4;
        r_bar_edge[4]   <= bw_x5;
        r_bar_edge[5]   <= bw_x3 << 1;
        r_bar_edge[6]   <= (bw_x1 << 3) - bw_x1;
        r_lower_edge[0] <= tw;
        r_lower_edge[1] <= tw << 1;
        r_lower_edge[2] <= (tw << 1) + tw;
        r_lower_edge[3] <= tw << 2;
        r_pluge_mid     <= bw_x5 + sw_x1;
        r_pluge_high    <= bw_x5 + (sw_x1 << 1);
        r_band3_top     <= r_h1 + ROW_W'(r_h2);
    end

    always_comb begin
        o_cfg.mode       = r_mode;
        o_cfg.fill       = r_fill;
        o_cfg.alpha      = r_alpha;
        o_cfg.w_last     = r_w_last;
        o_cfg.h_last     = r_h_last;
        o_cfg.cell_last  = r_cell_last;
        o_cfg.band2_top  = r_h1;
        o_cfg.band3_top  = r_band3_top;
        o_cfg.bar_edge   = r_bar_edge;
        o_cfg.lower_edge = r_lower_edge;
        o_cfg.pluge_mid  = r_pluge_mid;
        o_cfg.pluge_high = r_pluge_high;
    end

endmodule

>>> sv/video_test_pattern_generator.sv
// top level of the raster test pattern generator: scan counters, pixel pipeline
// depends on vtpg_pkg and vtpg_geom
`timescale 1ns / 1ps

// Usage
// - each request on the input channel (i_in_valid / o_in_stall) is one pixel
//   strobe; i_restart_frame marks pixel (0,0) and clears the scan position
// - each request on the output channel (o_out_valid / i_out_stall) carries
//   that pixel's rgba plus end of line and end of frame marks, in order
// - one pixel per clock sustained while the receiver does not stall; a taken
//   request passes the scan register, then the color register, to the output
// - the rate is set by the two-register pixel pipeline; bar edges are
//   divided out once, when a size register is written
// - configuration is a plain write port (i_cfg_we, i_cfg_index, i_cfg_data);
//   the user writes it only while no pixel is in flight; the block does not enforce it
// - reset: scan position and checker state go to zero, settings to solid
//   red, 1920x1080, alpha 255, checker cell 10, and the pipeline empties
// - while the receiver stalls, the output holds; the first stage takes a
//   request while it is empty or the output can load, so o_in_stall is up
//   only while both registers hold a pixel and the receiver stalls
module video_test_pattern_generator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [vtpg_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [vtpg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic                                 i_restart_frame,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [7:0]                           o_red,
    output logic [7:0]                           o_green,
    output logic [7:0]                           o_blue,
    output logic [7:0]                           o_alpha_out,
    output logic                                 o_end_of_line,
    output logic                                 o_end_of_frame
);

    localparam int POS_W  = vtpg_pkg::POS_W;
    localparam int ROW_W  = vtpg_pkg::ROW_W;
    localparam int EDGE_W = vtpg_pkg::EDGE_W;

    // bar index codes with a meaning of their own
    localparam logic [2:0] PLUGE_BAR = 3'd5;
    localparam logic [2:0] GRAY_BAR  = 3'd6;
    localparam logic [2:0] NO_BAR    = 3'd7;

    vtpg_pkg::t_cfg cfg;

    // scan state
    logic [POS_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [POS_W-1:0] r_ccnt;
    logic [ROW_W-1:0] r_rcnt;
    logic             r_cpar;
    logic             r_rpar;

    // first stage: position of the pixel
    logic             r_s1_valid;
    logic [POS_W-1:0] r_s1_col;
    logic [ROW_W-1:0] r_s1_row;
    logic             r_s1_par;
    logic             r_s1_eol;
    logic             r_s1_eof;

    // output stage
    logic             r_out_valid;
    logic [23:0]      r_rgb;
    logic [7:0]       r_alpha;
    logic             r_eol;
    logic             r_eof;

    logic             out_load;
    logic             in_take;

    logic [POS_W-1:0] p_col;
    logic [ROW_W-1:0] p_row;
    logic [POS_W-1:0] p_ccnt;
    logic [ROW_W-1:0] p_rcnt;
    logic             p_cpar;
    logic             p_rpar;
    logic             eol;
    logic             eof;
    logic [POS_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [POS_W-1:0] n_ccnt;
    logic [ROW_W-1:0] n_rcnt;
    logic             n_cpar;
    logic             n_rpar;

    logic [EDGE_W-1:0] x;
    logic [2:0]        bar_idx;
    logic [1:0]        lower_idx;
    logic              bars_paint;
    logic [23:0]       bars_rgb;
    logic              in_frame;
    logic [23:0]       n_rgb;
    logic [7:0]        n_alpha;

    vtpg_geom u_geom (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // pipeline flow: output loads when empty or taken, scan stage follows
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_s1_valid && !out_load;
    assign in_take    = i_in_valid && !o_in_stall;

    // scan position of this pixel and the position of the next one
    always_comb begin
        p_col  = i_restart_frame ? '0 : r_col;
        p_row  = i_restart_frame ? '0 : r_row;
        p_ccnt = i_restart_frame ? '0 : r_ccnt;
        p_rcnt = i_restart_frame ? '0 : r_rcnt;
        p_cpar = i_restart_frame ? 1'b0 : r_cpar;
        p_rpar = i_restart_frame ? 1'b0 : r_rpar;

        // past the last column or row also ends it, after a size change
        eol = p_col >= cfg.w_last;
        eof = eol && (p_row >= cfg.h_last);

        n_col  = p_col;
        n_row  = p_row;
        n_ccnt = p_ccnt;
        n_rcnt = p_rcnt;
        n_cpar = p_cpar;
        n_rpar = p_rpar;

        if (eol) begin
            n_col  = '0;
            n_ccnt = '0;
            n_cpar = 1'b0;
            if (eof) begin
                n_row  = '0;
                n_rcnt = '0;
                n_rpar = 1'b0;
            end else begin
                n_row = p_row + ROW_W'(1);
                if (32'(p_rcnt) >= 32'(cfg.cell_last)) begin
                    n_rcnt = '0;
                    n_rpar = !p_rpar;
                end else begin
                    n_rcnt = p_rcnt + ROW_W'(1);
                end
            end
        end else begin
            n_col = p_col + POS_W'(1);
            if (32'(p_ccnt) >= 32'(cfg.cell_last)) begin
                n_ccnt = '0;
                n_cpar = !p_cpar;
            end else begin
                n_ccnt = p_ccnt + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_ccnt      <= '0;
            r_rcnt      <= '0;
            r_cpar      <= 1'b0;
            r_rpar      <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_col  <= n_col;
                r_row  <= n_row;
                r_ccnt <= n_ccnt;
                r_rcnt <= n_rcnt;
                r_cpar <= n_cpar;
                r_rpar <= n_rpar;
            end
            if (!o_in_stall) begin
                r_s1_valid <= in_take;
            end
            if (out_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_col <= p_col;
            r_s1_row <= p_row;
            r_s1_par <= p_cpar ^ p_rpar;
            r_s1_eol <= eol;
            r_s1_eof <= eof;
        end
    end

    // bar pattern: parallel compares against the precomputed edges
    always_comb begin
        x = EDGE_W'(r_s1_col);

        bar_idx = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if (x >= cfg.bar_edge[k[2:0]]) begin
                bar_idx = 3'(k + 1);
            end
        end

        lower_idx = 2'd0;
        for (int k = 0; k < 3; k++) begin
            if (x >= cfg.lower_edge[k[1:0]]) begin
                lower_idx = 2'(k + 1);
            end
        end

        bars_paint = 1'b0;
        bars_rgb   = '0;
        if (r_s1_row < cfg.band2_top) begin
            if (bar_idx != NO_BAR) begin
                bars_paint = 1'b1;
                bars_rgb   = vtpg_pkg::UPPER_RGB[bar_idx];
            end
        end else if (r_s1_row < cfg.band3_top) begin
            if (bar_idx != NO_BAR) begin
                bars_paint = 1'b1;
                bars_rgb   = vtpg_pkg::SECOND_RGB[bar_idx];
            end
        end else if (x < cfg.lower_edge[3]) begin
            // lower bars win over the pluge cell
            bars_paint = 1'b1;
            bars_rgb   = vtpg_pkg::LOWER_RGB[lower_idx];
        end else if (bar_idx == PLUGE_BAR) begin
            bars_paint = 1'b1;
            if (x < cfg.pluge_mid) begin
                bars_rgb = vtpg_pkg::PLUGE_LOW_RGB;
            end else if (x < cfg.pluge_high) begin
                bars_rgb = vtpg_pkg::PLUGE_MID_RGB;
            end else begin
                bars_rgb = vtpg_pkg::PLUGE_HIGH_RGB;
            end
        end else if (bar_idx == GRAY_BAR) begin
            bars_paint = 1'b1;
            bars_rgb   = vtpg_pkg::GRAY_RGB;
        end
    end

    // mode select; pixels outside the frame stay transparent black
    always_comb begin
        in_frame = (r_s1_col <= cfg.w_last) && (r_s1_row <= cfg.h_last);
        n_rgb    = '0;
        n_alpha  = '0;
        if (in_frame) begin
            case (cfg.mode)
                vtpg_pkg::MODE_SOLID: begin
                    n_rgb   = cfg.fill;
                    n_alpha = cfg.alpha;
                end
                vtpg_pkg::MODE_BARS: begin
                    if (bars_paint) begin
                        n_rgb   = bars_rgb;
                        n_alpha = cfg.alpha;
                    end
                end
                vtpg_pkg::MODE_CHECKER: begin
                    n_rgb   = r_s1_par ? cfg.fill : '0;
                    n_alpha = cfg.alpha;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && r_s1_valid) begin
            r_rgb   <= n_rgb;
            r_alpha <= n_alpha;
            r_eol   <= r_s1_eol;
            r_eof   <= r_s1_eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red          = r_rgb[23:16];
    assign o_green        = r_rgb[15:8];
    assign o_blue         = r_rgb[7:0];
    assign o_alpha_out    = r_alpha;
    assign o_end_of_line  = r_eol;
    assign o_end_of_frame = r_eof;

endmodule

>>> sv/vtpg_checker.sv
// port-level checks of the test pattern generator, bound to the top level
// depends on video_test_pattern_generator_defines.svh
`timescale 1ns / 1ps
`include "video_test_pattern_generator_defines.svh"

module vtpg_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha_out,
    input  logic       i_end_of_line,
    input  logic       i_end_of_frame
);

    logic in_take;

    assign in_take = i_in_valid && !i_in_stall;

    // a frame always ends on a line end
    `VTPG_ASSERT_NOW(a_eof_has_eol, i_out_valid && i_end_of_frame, i_end_of_line, "end of frame without end of line")

    // input backs up only behind a full, stalled output
    `VTPG_ASSERT_NOW(a_stall_when_full, i_in_stall, i_out_valid && i_out_stall, "input stalled while output can move")

    // back-to-back free cycles with no new request drain both pipeline registers
    `VTPG_ASSERT_NEXT(a_drain, (!in_take && !i_out_stall) ##1 (!in_take && !i_out_stall), !i_out_valid, "pipeline did not drain")

    // a stalled result holds
    `VTPG_ASSERT_NEXT(a_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_red) && $stable(i_green) && $stable(i_blue) && $stable(i_alpha_out) && $stable(i_end_of_line) && $stable(i_end_of_frame), "stalled result changed")

endmodule

bind video_test_pattern_generator vtpg_checker u_vtpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .i_in_stall     (o_in_stall),
    .i_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .i_red          (o_red),
    .i_green        (o_green),
    .i_blue         (o_blue),
    .i_alpha_out    (o_alpha_out),
    .i_end_of_line  (o_end_of_line),
    .i_end_of_frame (o_end_of_frame)
);
